@@ hdl/assert_macros.svh @@
// Assertion macros shared by the integer-to-ASCII formatter files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, disabled while reset is high.
`define ITOA_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Clocked assertion that also holds during reset.
`define ITOA_ASSERT_ALWAYS(lbl, clk, prop, msg) \
   lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

@@ hdl/itoa_pkg.sv @@
// Package with types, constants and request layout for the integer-to-ASCII formatter.
`default_nettype none
package itoa_pkg;

   localparam int MAG_W       = 32;
   localparam int NDEC        = 10;
   localparam int NHEX        = 8;
   localparam int DIG_W       = NDEC * 4;
   localparam int NDIG_W      = 4;
   localparam int STEP_W      = $clog2(MAG_W + 1);
   localparam int FW_W        = 6;
   localparam int FW_CMP_W    = 7;
   localparam int MAX_WIDTH_DEFAULT = 32;

   localparam int REQ_TDATA_W = 40;
   localparam int VALUE_LSB   = 0;
   localparam int FW_LSB      = 32;
   localparam int ZF_BIT      = 38;

   localparam logic [7:0] PAD_ZERO_CHAR   = 8'h30;
   localparam logic [7:0] PAD_BLANK_CHAR  = 8'hFF;
   localparam logic [7:0] MINUS_CHAR      = 8'h4D;
   localparam logic [7:0] DIGIT_LOW_BASE  = 8'h30;
   localparam logic [7:0] DIGIT_HIGH_BASE = 8'h37;
   localparam logic [3:0] RADIX_DEC       = 4'd10;

   typedef struct packed {
      logic start;
      logic hex;
      logic shift;
   } conv_ctrl_type;

   typedef struct packed {
      logic              done;
      logic [NDIG_W-1:0] ndig;
   } conv_stat_type;

endpackage
`default_nettype wire

@@ hdl/itoa_conv.sv @@
// Digit generator: bit-serial binary to BCD conversion, hex load and leading-zero strip.
`default_nettype none
`include "assert_macros.svh"
module itoa_conv (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire itoa_pkg::conv_ctrl_type      ctrl,
   input  wire logic [itoa_pkg::MAG_W-1:0]   mag,
   output itoa_pkg::conv_stat_type           stat,
   output logic [3:0]                        digit
);
   import itoa_pkg::*;

   typedef enum logic [2:0] {
      C_IDLE   = 3'b001,
      C_DABBLE = 3'b010,
      C_NORM   = 3'b100
   } conv_state_type;

   conv_state_type    state_ff, state_in;
   logic [STEP_W-1:0] cnt_ff, cnt_in;
   logic [NDIG_W-1:0] ndig_ff, ndig_in;
   logic [DIG_W-1:0]  digits_ff, digits_in;
   logic [MAG_W-1:0]  shift_ff, shift_in;
   logic [DIG_W-1:0]  adj;
   logic              done;

   always_comb begin
      for (int i = 0; i < NDEC; i++) begin
         if (digits_ff[i*4 +: 4] >= 4'd5) begin
            adj[i*4 +: 4] = digits_ff[i*4 +: 4] + 4'd3;
         end else begin
            adj[i*4 +: 4] = digits_ff[i*4 +: 4];
         end
      end
   end

   always_comb begin
      state_in  = state_ff;
      cnt_in    = cnt_ff;
      ndig_in   = ndig_ff;
      digits_in = digits_ff;
      shift_in  = shift_ff;
      done      = 1'b0;
      case (state_ff)
         C_IDLE: begin
            if (ctrl.start) begin
               if (ctrl.hex) begin
                  digits_in = {mag, {(DIG_W - MAG_W){1'b0}}};
                  ndig_in   = NDIG_W'(NHEX);
                  state_in  = C_NORM;
               end else begin
                  digits_in = '0;
                  shift_in  = mag;
                  ndig_in   = NDIG_W'(NDEC);
                  cnt_in    = STEP_W'(MAG_W);
                  state_in  = C_DABBLE;
               end
            end else if (ctrl.shift) begin
               digits_in = {digits_ff[DIG_W-5:0], 4'h0};
            end
         end
         C_DABBLE: begin
            digits_in = {adj[DIG_W-2:0], shift_ff[MAG_W-1]};
            shift_in  = {shift_ff[MAG_W-2:0], 1'b0};
            cnt_in    = cnt_ff - STEP_W'(1);
            if (cnt_ff == STEP_W'(1)) begin
               state_in = C_NORM;
            end
         end
         C_NORM: begin
            if (digits_ff[DIG_W-1 -: 4] == 4'h0 && ndig_ff != NDIG_W'(1)) begin
               digits_in = {digits_ff[DIG_W-5:0], 4'h0};
               ndig_in   = ndig_ff - NDIG_W'(1);
            end else begin
               done     = 1'b1;
               state_in = C_IDLE;
            end
         end
         default: begin
            state_in = C_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= C_IDLE;
         cnt_ff   <= '0;
         ndig_ff  <= NDIG_W'(1);
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
         ndig_ff  <= ndig_in;
      end
   end

   always_ff @(posedge clock) begin
      digits_ff <= digits_in;
      shift_ff  <= shift_in;
   end

   assign stat.done = done;
   assign stat.ndig = ndig_ff;
   assign digit     = digits_ff[DIG_W-1 -: 4];

   `ITOA_ASSERT(a_dec_start, clock, reset, (state_ff == C_IDLE && ctrl.start && !ctrl.hex) |=> (state_ff == C_DABBLE && cnt_ff == STEP_W'(MAG_W)), "decimal conversion did not start with a full bit count")
   `ITOA_ASSERT(a_done_normalized, clock, reset, done |-> (digits_ff[DIG_W-1 -: 4] != 4'h0 || ndig_ff == NDIG_W'(1)), "digit string finished with a leading zero")
   `ITOA_ASSERT(a_ndig_nonzero, clock, reset, (state_ff == C_NORM) |-> (ndig_ff != '0 && ndig_ff <= NDIG_W'(NDEC)), "digit count out of range")

endmodule
`default_nettype wire

@@ hdl/int_to_ascii_padded.sv @@
// Top level of the integer-to-ASCII formatter: request intake, sequencer and output register.
//
// A request carries a signed 32-bit value, a base flag, a minimum field width and a pad
// choice. The block answers with a run of character bytes, most significant position
// first, with rsp_tlast on the final one. Widths above MAX_WIDTH are treated as MAX_WIDTH.
// Pad characters lead the field; for a negative value the last pad slot holds 'M', or an
// 'M' leads the digits when no pad is needed.
// The accepting cycle loads the converter. Decimal requests then run serial binary-to-BCD
// conversion over all 32 value bits. Both bases then strip leading zeros (up to 9 in
// decimal, up to 7 in hex), hand over to the sequencer, then send one character per cycle
// while the receiver accepts them; the next request can be accepted once the final
// character is in the output register.
// One request is in flight at a time; req_tready is high while the sequencer is idle,
// including while the final character still waits in the output register.
// When the receiver stalls, the output register holds its byte and the sequencer waits.
// Reset drops rsp_tvalid, returns the sequencer to idle and discards any partial run.
`default_nettype none
`include "assert_macros.svh"
module int_to_ascii_padded #(
   parameter int MAX_WIDTH = itoa_pkg::MAX_WIDTH_DEFAULT
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              req_tvalid,
   output logic                                   req_tready,
   // tdata: value[31:0], field_width[37:32], zero_fill[38], zero[39]
   input  wire logic [itoa_pkg::REQ_TDATA_W-1:0]  req_tdata,
   // tuser: func (0 decimal, 1 hexadecimal)
   input  wire logic                              req_tuser,
   output logic                                   rsp_tvalid,
   input  wire logic                              rsp_tready,
   // tdata: out_char[7:0]
   output logic [7:0]                             rsp_tdata,
   output logic                                   rsp_tlast
);
   import itoa_pkg::*;

   localparam int CNT_W = $clog2(MAX_WIDTH + 1);

   typedef enum logic [3:0] {
      S_IDLE  = 4'b0001,
      S_CONV  = 4'b0010,
      S_PAD   = 4'b0100,
      S_DIGIT = 4'b1000
   } seq_state_type;

   seq_state_type     state_ff, state_in;
   logic [CNT_W-1:0]  width_ff, width_in;
   logic [CNT_W-1:0]  pad_cnt_ff, pad_cnt_in;
   logic [NDIG_W-1:0] dig_cnt_ff, dig_cnt_in;
   logic              neg_ff, neg_in;
   logic              zero_fill_ff, zero_fill_in;
   logic              rsp_tvalid_ff, rsp_tvalid_in;
   logic [7:0]        char_ff, char_in;
   logic              last_ff, last_in;

   logic              req_fire;
   logic              out_free;
   logic              emit;
   logic [MAG_W-1:0]  value;
   logic [MAG_W-1:0]  mag;
   logic [FW_W-1:0]   fw;
   logic [CNT_W-1:0]  ndig_ext;
   logic [CNT_W-1:0]  pad_load;
   logic [3:0]        digit;
   logic [7:0]        digit_char;
   conv_ctrl_type     conv_ctrl;
   conv_stat_type     conv_stat;

   assign req_tready = (state_ff == S_IDLE);
   assign req_fire   = req_tvalid && req_tready;
   assign out_free   = !rsp_tvalid_ff || rsp_tready;

   assign value = req_tdata[VALUE_LSB +: MAG_W];
   assign mag   = value[MAG_W-1] ? (MAG_W'(0) - value) : value;
   assign fw    = req_tdata[FW_LSB +: FW_W];

   assign conv_ctrl.start = req_fire;
   assign conv_ctrl.hex   = req_tuser;
   assign conv_ctrl.shift = (state_ff == S_DIGIT) && out_free;

   itoa_conv u_conv (
      .clock (clock),
      .reset (reset),
      .ctrl  (conv_ctrl),
      .mag   (mag),
      .stat  (conv_stat),
      .digit (digit)
   );

   assign ndig_ext = CNT_W'(conv_stat.ndig);

   always_comb begin
      if (width_ff > ndig_ext) begin
         pad_load = width_ff - ndig_ext;
      end else if (neg_ff) begin
         pad_load = CNT_W'(1);
      end else begin
         pad_load = '0;
      end
   end

   assign digit_char = (digit < RADIX_DEC) ? (DIGIT_LOW_BASE + {4'h0, digit})
                                           : (DIGIT_HIGH_BASE + {4'h0, digit});

   always_comb begin
      state_in     = state_ff;
      width_in     = width_ff;
      pad_cnt_in   = pad_cnt_ff;
      dig_cnt_in   = dig_cnt_ff;
      neg_in       = neg_ff;
      zero_fill_in = zero_fill_ff;
      emit         = 1'b0;
      char_in      = char_ff;
      last_in      = last_ff;
      case (state_ff)
         S_IDLE: begin
            if (req_fire) begin
               neg_in       = value[MAG_W-1];
               zero_fill_in = req_tdata[ZF_BIT];
               if ({1'b0, fw} > FW_CMP_W'(MAX_WIDTH)) begin
                  width_in = CNT_W'(MAX_WIDTH);
               end else begin
                  width_in = CNT_W'(fw);
               end
               state_in = S_CONV;
            end
         end
         S_CONV: begin
            if (conv_stat.done) begin
               pad_cnt_in = pad_load;
               dig_cnt_in = conv_stat.ndig;
               state_in   = (pad_load != '0) ? S_PAD : S_DIGIT;
            end
         end
         S_PAD: begin
            if (out_free) begin
               emit    = 1'b1;
               last_in = 1'b0;
               if (neg_ff && pad_cnt_ff == CNT_W'(1)) begin
                  char_in = MINUS_CHAR;
               end else if (zero_fill_ff) begin
                  char_in = PAD_ZERO_CHAR;
               end else begin
                  char_in = PAD_BLANK_CHAR;
               end
               pad_cnt_in = pad_cnt_ff - CNT_W'(1);
               if (pad_cnt_ff == CNT_W'(1)) begin
                  state_in = S_DIGIT;
               end
            end
         end
         S_DIGIT: begin
            if (out_free) begin
               emit       = 1'b1;
               char_in    = digit_char;
               last_in    = (dig_cnt_ff == NDIG_W'(1));
               dig_cnt_in = dig_cnt_ff - NDIG_W'(1);
               if (dig_cnt_ff == NDIG_W'(1)) begin
                  state_in = S_IDLE;
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_comb begin
      if (emit) begin
         rsp_tvalid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_tvalid_in = 1'b0;
      end else begin
         rsp_tvalid_in = rsp_tvalid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         rsp_tvalid_ff <= 1'b0;
         pad_cnt_ff    <= '0;
         dig_cnt_ff    <= '0;
      end else begin
         state_ff      <= state_in;
         rsp_tvalid_ff <= rsp_tvalid_in;
         pad_cnt_ff    <= pad_cnt_in;
         dig_cnt_ff    <= dig_cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      width_ff     <= width_in;
      neg_ff       <= neg_in;
      zero_fill_ff <= zero_fill_in;
      char_ff      <= char_in;
      last_ff      <= last_in;
   end

   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = char_ff;
   assign rsp_tlast  = last_ff;

   `ITOA_ASSERT(a_last_digit_marked, clock, reset,
      (state_ff == S_DIGIT && out_free && dig_cnt_ff == NDIG_W'(1)) |=> (rsp_tvalid && rsp_tlast),
      "final digit left without tlast")
   `ITOA_ASSERT(a_pad_count_live, clock, reset, (state_ff == S_PAD) |-> (pad_cnt_ff != '0),
      "pad state entered with an empty pad count")
   `ITOA_ASSERT(a_digit_count_live, clock, reset, (state_ff == S_DIGIT) |-> (dig_cnt_ff != '0),
      "digit state entered with no digits left")

endmodule
`default_nettype wire
